// ----- hdl/content_length_deframer_top_macros.svh -----
// Assertion macros for the deframer.
`ifndef CONTENT_LENGTH_DEFRAMER_TOP_MACROS_SVH
`define CONTENT_LENGTH_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define CLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define CLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cld_pkg.sv -----
`default_nettype none

package cld_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last_of_message;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        MODE_PREFIX,
        MODE_SPACE,
        MODE_SIGN,
        MODE_DIGITS,
        MODE_DONE,
        MODE_IGNORE
    } t_mode;

    localparam logic [2:0] ST_BODY_BYTE   = 3'd0;
    localparam logic [2:0] ST_EMPTY_MSG   = 3'd1;
    localparam logic [2:0] ST_NO_LENGTH   = 3'd2;
    localparam logic [2:0] ST_END_HEADER  = 3'd3;
    localparam logic [2:0] ST_END_BODY    = 3'd4;
    localparam logic [2:0] ST_CLEAN_END   = 3'd5;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam int unsigned KEY_LEN = 15;

    // "content-length:" in lower case
    localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
        8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
    endfunction

    // Effect of a held-back CR that turned out to be a plain line byte.
    function automatic t_mode mode_after_cr(input t_mode m);
        t_mode r;
        r = m;
        case (m)
            MODE_PREFIX: r = MODE_IGNORE;
            MODE_SIGN:   r = MODE_IGNORE;
            MODE_DIGITS: r = MODE_DONE;
            default:     r = m;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/content_length_deframer_top.sv -----
// content_length_deframer_top: one stream byte per request in, body bytes and status out.
// The input register holds the accepted byte and feeds the result register (o_data).
// 1 byte per cycle when not stalled; header scan and body count step once per byte.
// A byte that yields no result still takes its slot; o_valid stays low for it.
// Reset (i_rst_n low, synchronous): header phase, all scan state cleared, both
// pipeline registers empty. No clearing pass.
`default_nettype none
`include "content_length_deframer_top_macros.svh"

module content_length_deframer_top #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire cld_pkg::t_in_item  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cld_pkg::t_out_item      o_data
);
    import cld_pkg::*;

    localparam int unsigned LB = LENGTH_BITS;
    localparam int unsigned WB = LENGTH_BITS + 4;   // room for acc*10 + digit

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic advance;  // result register can take a new value
    logic consume;  // the held input byte is consumed this cycle

    assign advance = !r_out_valid || i_ready;
    assign consume = advance && r_in_valid;
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    t_phase          r_phase, n_phase;
    logic [2:0]      r_term, n_term;        // progress through CR LF CR LF
    logic [3:0]      r_pos, n_pos;          // position in key prefix
    t_mode           r_mode, n_mode;
    logic            r_pend, n_pend;        // CR held back, waiting for LF
    logic [LB-1:0]   r_acc, n_acc;
    logic            r_digits, n_digits;
    logic            r_neg, n_neg;
    logic            r_over, n_over;
    logic            r_found, n_found;
    logic [LB-1:0]   r_flen, n_flen;
    logic            r_nonempty, n_nonempty;
    logic [LB-1:0]   r_rem, n_rem;

    // ------------------------------------------------------------------
    // Header scan: one header byte against the line state
    // ------------------------------------------------------------------
    logic [7:0]    c;
    logic          feed_en;
    logic          close_en;
    t_mode         feed_mode;
    logic          add_en;
    logic [WB-1:0] acc_wide;
    logic          close_ok;
    logic          hdr_done;
    logic [2:0]    s_term;
    logic          s_pend;
    t_mode         s_mode;
    logic [3:0]    s_pos;
    logic [LB-1:0] s_acc;
    logic          s_digits, s_neg, s_over;
    logic          s_found;
    logic [LB-1:0] s_flen;

    assign c = r_in.in_byte;

    // acc*10 + digit as two shifts and adds
    assign acc_wide = (WB'(r_acc) << 3) + (WB'(r_acc) << 1) + WB'(c[3:0]);

    assign close_ok = !r_found && (r_mode == MODE_DIGITS || r_mode == MODE_DONE)
                      && r_digits && !r_over && (!r_neg || r_acc == '0);

    always_comb begin
        feed_en   = 1'b0;
        close_en  = 1'b0;
        feed_mode = r_mode;
        s_pend    = r_pend;
        if (r_pend) begin
            s_pend = 1'b0;
            if (c == CHAR_LF) begin
                close_en = 1'b1;
            end else begin
                // the held CR becomes an ordinary line byte
                feed_mode = mode_after_cr(r_mode);
                if (c == CHAR_CR) begin
                    s_pend = 1'b1;
                end else begin
                    feed_en = 1'b1;
                end
            end
        end else if (c == CHAR_CR) begin
            s_pend = 1'b1;
        end else begin
            feed_en = 1'b1;
        end
    end

    // line byte against the current mode
    always_comb begin
        s_mode   = feed_mode;
        s_pos    = r_pos;
        s_neg    = r_neg;
        add_en   = 1'b0;
        if (feed_en) begin
            case (feed_mode)
                MODE_PREFIX: begin
                    if (to_lower(c) != KEY_TEXT[r_pos] || r_pos >= 4'(KEY_LEN)) begin
                        s_mode = MODE_IGNORE;
                    end else begin
                        s_pos = r_pos + 4'd1;
                        if (r_pos == 4'(KEY_LEN - 1)) begin
                            s_mode = MODE_SPACE;
                        end
                    end
                end
                MODE_SPACE: begin
                    if (is_space(c)) begin
                        s_mode = MODE_SPACE;
                    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        s_neg  = r_neg || (c == CHAR_MINUS);
                        s_mode = MODE_SIGN;
                    end else if (is_digit(c)) begin
                        add_en = 1'b1;
                        s_mode = MODE_DIGITS;
                    end else begin
                        s_mode = MODE_IGNORE;
                    end
                end
                MODE_SIGN: begin
                    if (is_digit(c)) begin
                        add_en = 1'b1;
                        s_mode = MODE_DIGITS;
                    end else begin
                        s_mode = MODE_IGNORE;
                    end
                end
                MODE_DIGITS: begin
                    if (is_digit(c)) begin
                        add_en = 1'b1;
                    end else begin
                        s_mode = MODE_DONE;
                    end
                end
                default: s_mode = feed_mode;
            endcase
        end
    end

    // digit accumulate with overflow latch, line close, terminator tracking
    always_comb begin
        s_acc    = r_acc;
        s_digits = r_digits;
        s_over   = r_over;
        s_found  = r_found;
        s_flen   = r_flen;
        if (add_en) begin
            s_digits = 1'b1;
            if (!r_over) begin
                if (acc_wide[WB-1:LB] != '0) begin
                    s_over = 1'b1;
                end else begin
                    s_acc = acc_wide[LB-1:0];
                end
            end
        end
        if (close_en && close_ok) begin
            s_found = 1'b1;
            s_flen  = r_acc;
        end

        // terminator: CR LF CR LF, even index wants CR, odd wants LF
        if (c == (r_term[0] ? CHAR_LF : CHAR_CR)) begin
            s_term = r_term + 3'd1;
        end else begin
            s_term = (c == CHAR_CR) ? 3'd1 : 3'd0;
        end
        hdr_done = s_term[2];
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_phase    = r_phase;
        n_term     = r_term;
        n_pos      = r_pos;
        n_mode     = r_mode;
        n_pend     = r_pend;
        n_acc      = r_acc;
        n_digits   = r_digits;
        n_neg      = r_neg;
        n_over     = r_over;
        n_found    = r_found;
        n_flen     = r_flen;
        n_nonempty = r_nonempty;
        n_rem      = r_rem;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_in.end_of_input) begin
                    n_phase = PH_HALT;
                end else if (hdr_done) begin
                    // header finished: scan state starts clean for the next header
                    n_term     = '0;
                    n_pos      = '0;
                    n_mode     = MODE_PREFIX;
                    n_pend     = 1'b0;
                    n_acc      = '0;
                    n_digits   = 1'b0;
                    n_neg      = 1'b0;
                    n_over     = 1'b0;
                    n_found    = 1'b0;
                    n_flen     = '0;
                    n_nonempty = 1'b0;
                    if (!s_found) begin
                        n_phase = PH_HALT;
                    end else if (s_flen != '0) begin
                        n_phase = PH_BODY;
                        n_rem   = s_flen;
                    end
                end else begin
                    n_term     = s_term;
                    n_pend     = s_pend;
                    n_nonempty = 1'b1;
                    if (close_en) begin
                        n_pos    = '0;
                        n_mode   = MODE_PREFIX;
                        n_acc    = '0;
                        n_digits = 1'b0;
                        n_neg    = 1'b0;
                        n_over   = 1'b0;
                        n_found  = s_found;
                        n_flen   = s_flen;
                    end else begin
                        n_pos    = s_pos;
                        n_mode   = s_mode;
                        n_acc    = s_acc;
                        n_digits = s_digits;
                        n_neg    = s_neg;
                        n_over   = s_over;
                    end
                end
            end
            PH_BODY: begin
                if (r_in.end_of_input) begin
                    n_phase = PH_HALT;
                end else if (r_rem[LB-1:1] == '0) begin
                    n_phase = PH_HEADER;
                    n_rem   = '0;
                end else begin
                    n_rem = r_rem - LB'(1);
                end
            end
            default: n_phase = PH_HALT;
        endcase
    end

    // ------------------------------------------------------------------
    // Result for the byte being consumed
    // ------------------------------------------------------------------
    logic      res_valid;
    t_out_item res;

    always_comb begin
        res_valid           = 1'b0;
        res.out_byte        = '0;
        res.status          = ST_BODY_BYTE;
        res.last_of_message = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if (r_in.end_of_input) begin
                    res_valid  = 1'b1;
                    res.status = r_nonempty ? ST_END_HEADER : ST_CLEAN_END;
                end else if (hdr_done) begin
                    if (!s_found) begin
                        res_valid  = 1'b1;
                        res.status = ST_NO_LENGTH;
                    end else if (s_flen == '0) begin
                        res_valid           = 1'b1;
                        res.status          = ST_EMPTY_MSG;
                        res.last_of_message = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                res_valid = 1'b1;
                if (r_in.end_of_input) begin
                    res.status = ST_END_BODY;
                end else begin
                    res.out_byte        = c;
                    res.last_of_message = (r_rem[LB-1:1] == '0);
                end
            end
            default: res_valid = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in <= i_data;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_term      <= '0;
            r_pos       <= '0;
            r_mode      <= MODE_PREFIX;
            r_pend      <= 1'b0;
            r_acc       <= '0;
            r_digits    <= 1'b0;
            r_neg       <= 1'b0;
            r_over      <= 1'b0;
            r_found     <= 1'b0;
            r_flen      <= '0;
            r_nonempty  <= 1'b0;
            r_rem       <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= consume && res_valid;
            end
            if (consume) begin
                r_phase    <= n_phase;
                r_term     <= n_term;
                r_pos      <= n_pos;
                r_mode     <= n_mode;
                r_pend     <= n_pend;
                r_acc      <= n_acc;
                r_digits   <= n_digits;
                r_neg      <= n_neg;
                r_over     <= n_over;
                r_found    <= n_found;
                r_flen     <= n_flen;
                r_nonempty <= n_nonempty;
                r_rem      <= n_rem;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CLD_ASSERT_NEXT(a_halt_sticks, r_phase == PH_HALT, r_phase == PH_HALT, "left halt")
    `CLD_ASSERT_NOW(a_body_count, r_phase == PH_BODY, r_rem != '0, "body with zero count")
    `CLD_ASSERT_NOW(a_status_byte, o_valid && o_data.status != ST_BODY_BYTE,
        o_data.out_byte == 8'd0, "nonzero byte on status result")

endmodule

`default_nettype wire

// ----- tb/content_length_deframer_top_test.sv -----
`timescale 1ns / 1ps

// Testbench for content_length_deframer_top.
// A cycle-level scoreboard: every byte request that the block accepts is run
// through a local deframer model, and whatever result that byte causes is
// queued. The output monitor pops one expectation per accepted result and
// compares it field by field.
// The block halts for good on end of input or on a header without a usable
// length, and reset is applied only once. So the whole run is one long stream
// of well-formed messages with random content, and exactly one way of ending
// the stream, picked at random, is exercised at the very end.

module content_length_deframer_top_test;

    import cld_pkg::*;

    localparam int unsigned LENGTH_BITS  = 32;
    localparam logic [63:0] LEN_MAX      = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 4;      // two pipeline stages plus margin
    localparam int          BYTES_TARGET = 1150;   // stop point for the random part
    localparam int          HOLD_CYCLES  = 200;    // long output hold-off
    localparam int          HALT_BYTES   = 12;     // requests offered after the halt

    // Kinds of header lines that look like a length line but must not set it.
    typedef enum int {
        BAD_NEGATIVE,
        BAD_TOO_WIDE,
        BAD_NO_DIGITS,
        BAD_SIGN_ONLY,
        BAD_NEAR_KEY,
        BAD_CR_IN_KEY,
        BAD_NO_COLON,
        BAD_EMPTY_VALUE,
        BAD_LEAD_SPACE,
        BAD_KIND_COUNT
    } t_bad_line;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_in_item  i_data  = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_data;

    content_length_deframer_top #(
        .LENGTH_BITS(LENGTH_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_out_item   expected_results[$];   // results still owed by the block
    logic [7:0]  line_buf[$];           // header line being assembled

    logic        idle_on      = 1'b1;   // random idling on both sides
    int          hold_off_len = 0;      // set by a test to ask for a long stall
    int          hold_count   = 0;      // stall cycles left, owned by the receiver
    int          cycle_count  = 0;
    int          fail_count   = 0;
    int          items_accepted = 0;

    // run statistics, gathered by the monitor
    int          body_bytes_seen = 0;
    int          messages_seen   = 0;
    int          empty_seen      = 0;
    logic [2:0]  terminal_status = ST_BODY_BYTE;
    t_out_item   result_want;

    // ------------------------------------------------------------------
    // Deframer model: state, some of it wider than the block's widths
    // ------------------------------------------------------------------
    t_phase      dfr_phase;
    logic [2:0]  term_cnt;       // progress through CR LF CR LF
    logic [4:0]  key_pos;        // bytes of the key matched so far
    t_mode       scan_mode;
    logic        cr_held;        // CR seen, waiting to know if LF follows
    logic [63:0] acc;
    logic        saw_digit;
    logic        minus;
    logic        too_wide;
    logic        len_found;
    logic [63:0] len_val;
    logic        hdr_seen;
    logic [63:0] remaining;

    function automatic logic ws_char(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic dec_char(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    task automatic clear_line();
        key_pos   = '0;
        scan_mode = MODE_PREFIX;
        acc       = '0;
        saw_digit = 1'b0;
        minus     = 1'b0;
        too_wide  = 1'b0;
    endtask

    task automatic clear_header();
        term_cnt  = '0;
        cr_held   = 1'b0;
        len_found = 1'b0;
        len_val   = '0;
        hdr_seen  = 1'b0;
        clear_line();
    endtask

    // Accumulate one decimal digit; once too wide the value stops growing.
    task automatic add_digit(input logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - 8'h30};
        saw_digit = 1'b1;
        if (!too_wide) begin
            if (acc > (LEN_MAX - d) / 64'd10)
                too_wide = 1'b1;
            else
                acc = acc * 64'd10 + d;
        end
    endtask

    // One ordinary line byte through the key / value scanner.
    task automatic scan_byte(input logic [7:0] c);
        case (scan_mode)
            MODE_PREFIX: begin
                if (key_pos >= KEY_LEN || fold_case(c) != KEY_TEXT[key_pos[3:0]]) begin
                    scan_mode = MODE_IGNORE;
                end else begin
                    key_pos = key_pos + 5'd1;
                    if (key_pos == KEY_LEN)
                        scan_mode = MODE_SPACE;
                end
            end
            MODE_SPACE: begin
                if (ws_char(c)) begin
                    scan_mode = MODE_SPACE;
                end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                    if (c == CHAR_MINUS)
                        minus = 1'b1;
                    scan_mode = MODE_SIGN;
                end else if (dec_char(c)) begin
                    add_digit(c);
                    scan_mode = MODE_DIGITS;
                end else begin
                    scan_mode = MODE_IGNORE;
                end
            end
            MODE_SIGN: begin
                if (dec_char(c)) begin
                    add_digit(c);
                    scan_mode = MODE_DIGITS;
                end else begin
                    scan_mode = MODE_IGNORE;
                end
            end
            MODE_DIGITS: begin
                if (dec_char(c))
                    add_digit(c);
                else
                    scan_mode = MODE_DONE;
            end
            default: ;
        endcase
    endtask

    // End of line: the first usable value wins; minus zero counts as zero.
    task automatic close_line();
        if (!len_found && (scan_mode == MODE_DIGITS || scan_mode == MODE_DONE) &&
                saw_digit && !too_wide && (!minus || acc == '0)) begin
            len_found = 1'b1;
            len_val   = acc;
        end
        clear_line();
    endtask

    task automatic header_byte(input logic [7:0] c, output logic hdr_done);
        logic [7:0] term_want;
        hdr_seen = 1'b1;
        if (cr_held) begin
            cr_held = 1'b0;
            if (c == CHAR_LF) begin
                close_line();
            end else begin
                // the held CR was a plain byte after all
                scan_byte(CHAR_CR);
                if (c == CHAR_CR)
                    cr_held = 1'b1;
                else
                    scan_byte(c);
            end
        end else if (c == CHAR_CR) begin
            cr_held = 1'b1;
        end else begin
            scan_byte(c);
        end

        term_want = term_cnt[0] ? CHAR_LF : CHAR_CR;
        if (c == term_want)
            term_cnt = term_cnt + 3'd1;
        else
            term_cnt = (c == CHAR_CR) ? 3'd1 : 3'd0;
        hdr_done = (term_cnt >= 3'd4);
    endtask

    // One accepted request through the model; at most one result.
    task automatic deframe_step(input t_in_item item, output logic got, output t_out_item res);
        logic hdr_done;
        got = 1'b0;
        res = '0;
        case (dfr_phase)
            PH_HEADER: begin
                if (item.end_of_input) begin
                    res.status = hdr_seen ? ST_END_HEADER : ST_CLEAN_END;
                    dfr_phase  = PH_HALT;
                    got        = 1'b1;
                end else begin
                    header_byte(item.in_byte, hdr_done);
                    if (hdr_done) begin
                        if (!len_found) begin
                            res.status = ST_NO_LENGTH;
                            dfr_phase  = PH_HALT;
                            got        = 1'b1;
                        end else if (len_val == '0) begin
                            clear_header();
                            res.status          = ST_EMPTY_MSG;
                            res.last_of_message = 1'b1;
                            got                 = 1'b1;
                        end else begin
                            remaining = len_val & LEN_MAX;
                            dfr_phase = PH_BODY;
                        end
                    end
                end
            end
            PH_BODY: begin
                got = 1'b1;
                if (item.end_of_input) begin
                    res.status = ST_END_BODY;
                    dfr_phase  = PH_HALT;
                end else begin
                    res.out_byte = item.in_byte;
                    res.status   = ST_BODY_BYTE;
                    if (remaining <= 64'd1) begin
                        remaining           = '0;
                        dfr_phase           = PH_HEADER;
                        res.last_of_message = 1'b1;
                        clear_header();
                    end else begin
                        remaining = remaining - 64'd1;
                    end
                end
            end
            default: ;   // halted: everything is dropped
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Called right after a rising edge. Valid is lowered only when a gap is
    // taken, so back-to-back requests never drop valid within one step.
    task automatic send_request(input t_in_item item);
        logic      got;
        t_out_item res;
        if (idle_on && $urandom_range(0, 99) < 12) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // accepted at this edge
        deframe_step(item, got, res);
        if (got)
            expected_results.insert(expected_results.size(), res);
        items_accepted++;
    endtask

    task automatic send_stream_byte(input logic [7:0] b);
        t_in_item item;
        item.in_byte      = b;
        item.end_of_input = 1'b0;
        send_request(item);
    endtask

    task automatic send_end_of_input();
        t_in_item item;
        item.in_byte      = 8'($urandom_range(0, 255));
        item.end_of_input = 1'b1;
        send_request(item);
    endtask

    // Bare CR LF: closes the header when it follows a line end.
    task automatic send_blank_line();
        send_stream_byte(CHAR_CR);
        send_stream_byte(CHAR_LF);
    endtask

    // Pause the sender until every owed result has come back, plus latency.
    // Polled on the falling edge so the monitor's pop never races the test.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Header line builders
    // ------------------------------------------------------------------
    task automatic append_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    task automatic line_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    // Key with random letter case
    task automatic line_key();
        logic [7:0] c;
        for (int i = 0; i < KEY_LEN; i++) begin
            c = KEY_TEXT[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
                c = c - 8'h20;
            append_byte(c);
        end
    endtask

    // Up to three blanks, drawn from every character the scanner skips
    task automatic line_ws();
        logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        repeat ($urandom_range(0, 3))
            append_byte(blanks[$urandom_range(0, 5)]);
    endtask

    task automatic put_good_line(input logic [63:0] v);
        string      trail = " ;x";
        int         r;
        line_key();
        line_ws();
        r = $urandom_range(0, 99);
        if (v == '0 && r < 20)
            line_text("-");
        else if (r < 35)
            line_text("+");
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) line_text("0");
        line_text($sformatf("%0d", v));
        // junk after the digits, sometimes a stray CR
        if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 3) == 0)
                append_byte(CHAR_CR);
            else
                append_byte(trail[$urandom_range(0, 2)]);
            repeat ($urandom_range(0, 4))
                append_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic put_bad_line(input t_bad_line kind);
        int pos;
        case (kind)
            BAD_NEGATIVE: begin
                line_key();
                line_ws();
                line_text($sformatf("-%0d", $urandom_range(1, 99)));
            end
            BAD_TOO_WIDE: begin
                line_key();
                line_ws();
                if ($urandom_range(0, 1)) begin
                    line_text("4294967296");   // one past the largest length
                end else begin
                    append_byte(8'(8'h30 + $urandom_range(1, 9)));
                    repeat ($urandom_range(10, 16))
                        append_byte(8'(8'h30 + $urandom_range(0, 9)));
                end
            end
            BAD_NO_DIGITS: begin
                line_key();
                line_ws();
                line_text("abc");
            end
            BAD_SIGN_ONLY: begin
                line_key();
                line_ws();
                line_text($urandom_range(0, 1) ? "+" : "-");
                if ($urandom_range(0, 1))
                    line_text(" 5");
            end
            BAD_NEAR_KEY: begin
                line_key();
                pos = $urandom_range(0, KEY_LEN - 1);
                line_buf[pos] = line_buf[pos] ^ 8'h01;
                line_text(" 7");
            end
            BAD_CR_IN_KEY: begin
                line_key();
                line_buf.insert($urandom_range(1, KEY_LEN - 1), CHAR_CR);
                line_text(" 5");
            end
            BAD_NO_COLON: begin
                line_key();
                line_buf[KEY_LEN - 1] = 8'h20;
                line_text("5");
            end
            BAD_EMPTY_VALUE: begin
                line_key();
                line_ws();
            end
            default: begin   // key not at line start
                line_text(" ");
                line_key();
                line_text("5");
            end
        endcase
    endtask

    task automatic put_noise_line();
        repeat ($urandom_range(1, 16))
            append_byte(8'($urandom_range(0, 255)));
    endtask

    // Send the assembled line and its CR LF. A LF right after a CR inside the
    // line would end it early, so such a LF becomes a blank; an empty line
    // would end the header, so it gets one byte.
    task automatic send_line();
        if (line_buf.size() == 0)
            append_byte(8'h78);
        for (int i = 1; i < line_buf.size(); i++)
            if (line_buf[i - 1] == CHAR_CR && line_buf[i] == CHAR_LF)
                line_buf[i] = 8'h20;
        foreach (line_buf[i])
            send_stream_byte(line_buf[i]);
        line_buf.delete();
        send_blank_line();
    endtask

    // Mostly short bodies, some zero, a few longer.
    function automatic logic [63:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 64'd0;
        else if (r < 80)
            return 64'($urandom_range(1, 12));
        return 64'($urandom_range(13, 48));
    endfunction

    // Body bytes follow the model's phase, so a body is always exactly as
    // long as the header asked for.
    task automatic send_body();
        while (dfr_phase == PH_BODY)
            send_stream_byte(8'($urandom_range(0, 255)));
    endtask

    // A well-formed message: decoy and noise lines, one usable length line,
    // then more lines that must not override it.
    task automatic send_message();
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1))
                put_bad_line(t_bad_line'($urandom_range(0, BAD_KIND_COUNT - 1)));
            else
                put_noise_line();
            send_line();
        end
        put_good_line(pick_length());
        send_line();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0:       put_noise_line();
                1:       put_bad_line(t_bad_line'($urandom_range(0, BAD_KIND_COUNT - 1)));
                default: put_good_line($urandom_range(0, 1) ? LEN_MAX : pick_length());
            endcase
            send_line();
        end
        send_blank_line();
        send_body();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Minus zero in upper case gives an empty message; then a two byte body
    // with the extreme byte values.
    task automatic test_directed_extremes();
        line_text("CONTENT-LENGTH:-0");
        send_line();
        send_blank_line();
        line_text("content-length:+2");
        send_line();
        send_blank_line();
        send_stream_byte(8'h00);
        send_stream_byte(8'hFF);
    endtask

    // Every decoy kind ahead of the real length line, with the largest
    // length after it that must lose to the first.
    task automatic test_length_line_rules();
        for (int k = 0; k < BAD_KIND_COUNT; k++) begin
            put_bad_line(t_bad_line'(k));
            send_line();
            put_good_line(pick_length());
            send_line();
            put_good_line(LEN_MAX);
            send_line();
            send_blank_line();
            send_body();
        end
    endtask

    // Full rate on both sides for a few messages.
    task automatic test_steady_stream();
        idle_on <= 1'b0;
        repeat (3) send_message();
        idle_on <= 1'b1;
    endtask

    // Receiver stalls long while a 40 byte body keeps coming, so the block
    // must fill and drop o_ready; then the sender waits for the drain.
    task automatic test_output_hold_off();
        hold_off_len <= HOLD_CYCLES;
        line_key();
        line_text(" 40");
        send_line();
        send_blank_line();
        send_body();
        wait_drained();
    endtask

    task automatic test_random_messages();
        while (items_accepted < BYTES_TARGET)
            send_message();
    endtask

    // One way of ending the stream, then requests that must be dropped.
    task automatic test_stream_end();
        logic [2:0] end_kinds [4] = '{ST_CLEAN_END, ST_END_HEADER, ST_END_BODY, ST_NO_LENGTH};
        t_in_item   item;
        case (end_kinds[$urandom_range(0, 3)])
            ST_CLEAN_END: begin
                send_end_of_input();
            end
            ST_END_HEADER: begin
                line_key();
                line_text(" 3");
                send_line();
                line_text("X-Pad: 1");
                foreach (line_buf[i])
                    send_stream_byte(line_buf[i]);
                line_buf.delete();
                send_end_of_input();
            end
            ST_END_BODY: begin
                // largest length that is still accepted, cut short
                line_key();
                line_text(" 4294967295");
                send_line();
                send_blank_line();
                repeat ($urandom_range(1, 5))
                    send_stream_byte(8'($urandom_range(0, 255)));
                send_end_of_input();
            end
            default: begin
                repeat ($urandom_range(1, 2)) begin
                    put_bad_line(t_bad_line'($urandom_range(0, BAD_KIND_COUNT - 1)));
                    send_line();
                end
                send_blank_line();
            end
        endcase
        repeat (HALT_BYTES) begin
            item.in_byte      = 8'($urandom_range(0, 255));
            item.end_of_input = 1'($urandom_range(0, 1));
            send_request(item);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, or a long hold-off counted here
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_count != 0) begin
            i_ready    <= 1'b0;
            hold_count <= hold_count - 1;
        end else if (hold_off_len != 0) begin
            i_ready      <= 1'b0;
            hold_count   <= hold_off_len - 1;
            hold_off_len <= 0;
        end else if (idle_on) begin
            i_ready <= ($urandom_range(0, 99) >= 20);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: byte %h status %0d last %0b",
                         $time, o_data.out_byte, o_data.status, o_data.last_of_message);
                fail_count++;
            end else begin
                result_want = expected_results.pop_front();
                if (o_data.out_byte != result_want.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, result_want.out_byte, o_data.out_byte);
                    fail_count++;
                end
                if (o_data.status != result_want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, result_want.status, o_data.status);
                    fail_count++;
                end
                if (o_data.last_of_message != result_want.last_of_message) begin
                    $display("%0t: last_of_message expected %0b actual %0b",
                             $time, result_want.last_of_message, o_data.last_of_message);
                    fail_count++;
                end
                if (result_want.status == ST_BODY_BYTE)
                    body_bytes_seen++;
                else if (result_want.status == ST_EMPTY_MSG)
                    empty_seen++;
                else
                    terminal_status = result_want.status;
                if (result_want.last_of_message)
                    messages_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit hit, %0d results still owed",
                     $time, expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        dfr_phase = PH_HEADER;
        remaining = '0;
        clear_header();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_length_line_rules();
        test_steady_stream();
        test_output_hold_off();
        test_random_messages();
        test_stream_end();
        wait_drained();

        $display("Covered %0d stream bytes: %0d messages (%0d empty), %0d body bytes.",
                 items_accepted, messages_seen, empty_seen, body_bytes_seen);
        $display("Stream closed with status %0d, then %0d requests were dropped.",
                 terminal_status, HALT_BYTES);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cld_pkg.sv
hdl/content_length_deframer_top.sv
tb/content_length_deframer_top_test.sv
